### rtl/core/swtm_pkg.sv
// Shared types and constants for the sliding-window trimmed mean unit.
// No dependencies; imported by the controller, datapath and top level.
package swtm_pkg;

  // register indexes on the configuration port
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [0:0] REG_TRIM_COUNT  = 1'b1;

  localparam int WSIZE_BITS = 6;
  localparam int TRIM_BITS  = 4;
  localparam int AVG_BITS   = 16;

  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 6'd32;
  localparam logic [TRIM_BITS-1:0]  TRIM_RESET  = 4'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic remove;
    logic insert;
    logic sum_step;
    logic div_start;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic sum_done;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

### rtl/core/swtm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module swtm_div #(
  parameter int SW = 21,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [SW-1:0] quotient
);

  localparam int CNTW = $clog2(SW + 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [SW-1:0]   quot_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   dvs_r;
  logic [DW:0]     rem_sh;
  logic            take;

  // trial subtraction
  assign rem_sh = {rem_r, quot_r[SW-1]};
  assign take   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(SW);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[SW-2:0], take};
      rem_r  <= take ? DW'(rem_sh - {1'b0, dvs_r}) : DW'(rem_sh);
    end
  end

  assign busy     = busy_r;
  assign quotient = quot_r;

endmodule

### rtl/core/swtm_ctrl.sv
// Sequencer for the trimmed mean unit: one word at a time through
// remove, insert, sum, divide (if full), output. Uses swtm_pkg.
module swtm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  input  swtm_pkg::sts_t sts,
  output logic           in_ready,
  output swtm_pkg::cmd_t cmd
);
  import swtm_pkg::*;

  state_t state_r, state_nxt;
  logic   load;

  assign load = !sts.out_busy || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_REMOVE;
      S_REMOVE: state_nxt = S_INSERT;
      S_INSERT: state_nxt = S_SUM;
      S_SUM: begin
        if (!sts.full)         state_nxt = S_OUT;
        else if (sts.sum_done) state_nxt = S_DIV;
      end
      S_DIV:    if (!sts.div_busy) state_nxt = S_OUT;
      S_OUT:    if (load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_REMOVE: cmd.remove = 1'b1;
      S_INSERT: cmd.insert = 1'b1;
      S_SUM: begin
        cmd.sum_step  = sts.full && !sts.sum_done;
        cmd.div_start = sts.full && sts.sum_done;
      end
      S_DIV:    ;
      S_OUT:    cmd.out_load = load;
      default:  ;
    endcase
  end

endmodule

### rtl/core/swtm_dp.sv
// Datapath: sample ring, sorted cell row, middle sum and divider.
// Uses swtm_pkg and swtm_div.
module swtm_dp #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swtm_pkg::cmd_t                     cmd,
  input  logic                               clear,
  input  logic [swtm_pkg::WSIZE_BITS-1:0]    cfg_wsize,
  input  logic [swtm_pkg::TRIM_BITS-1:0]     cfg_trim,
  input  logic [SAMPLE_BITS-1:0]             in_sample,
  input  logic                               out_ready,
  output swtm_pkg::sts_t                     sts,
  output logic                               out_valid,
  output logic [swtm_pkg::AVG_BITS-1:0]      out_average,
  output logic                               out_ready_res
);
  import swtm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW = SAMPLE_BITS + CW;

  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] cell_r   [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] cell_nxt [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rem_v    [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] ins_v    [MAX_WINDOW];

  logic [SAMPLE_BITS-1:0] s_r, ring_q_r;
  logic [CW-1:0]          w_r, t_r, fill_r, idx_r;
  logic [PW-1:0]          wp_r, wp_use;
  logic [SW-1:0]          sum_r, quot;
  logic                   out_valid_r, out_ready_res_r;
  logic [AVG_BITS-1:0]    out_average_r;
  logic [CW-1:0]          w_eff, t_eff, n_ins, wp_inc;
  logic                   full, div_busy;
  logic [31:0]            wx, tx;

  // effective window and trim from the registers
  always_comb begin
    wx = 32'(cfg_wsize);
    if (wx < 32'd3) wx = 32'd3;
    if (wx > 32'(MAX_WINDOW)) wx = 32'(MAX_WINDOW);
    tx = 32'(cfg_trim);
    if (2 * tx >= wx) tx = (wx - 32'd1) >> 1;
    w_eff = CW'(wx);
    t_eff = CW'(tx);
  end

  assign wp_use = ({1'b0, wp_r} >= (PW+1)'(w_eff)) ? '0 : wp_r;
  assign wp_inc = CW'(wp_r) + 1'b1;
  assign full   = fill_r >= w_r;
  assign n_ins  = full ? w_r - 1'b1 : fill_r;

  // removal of the oldest value: first match closes up from above
  always_comb begin
    logic found;
    found = 1'b0;
    for (int j = 0; j < MAX_WINDOW; j++) rem_v[j] = cell_r[j];
    for (int j = 0; j < MAX_WINDOW - 1; j++) begin
      if (CW'(j) < w_r && cell_r[j] == ring_q_r) found = 1'b1;
      if (found && CW'(j + 1) < w_r) rem_v[j] = cell_r[j + 1];
    end
  end

  // insertion: larger values move up one cell
  always_comb begin
    logic                   gt, gt_prev;
    logic [SAMPLE_BITS-1:0] prev_v;
    gt_prev = 1'b0;
    prev_v  = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      gt = CW'(j) < n_ins && cell_r[j] > s_r;
      if (gt_prev)                    ins_v[j] = prev_v;
      else if (gt || CW'(j) == n_ins) ins_v[j] = s_r;
      else                            ins_v[j] = cell_r[j];
      gt_prev = gt;
      prev_v  = cell_r[j];
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (cmd.remove && full) cell_nxt[j] = rem_v[j];
      else if (cmd.insert)    cell_nxt[j] = ins_v[j];
      else                    cell_nxt[j] = cell_r[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_WINDOW; j++) cell_r[j] <= cell_nxt[j];
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.remove) ring_mem[wp_r] <= s_r;
    if (cmd.start)  ring_q_r <= ring_mem[wp_use];
  end

  // word capture, middle sum
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      s_r <= in_sample;
      w_r <= w_eff;
      t_r <= t_eff;
    end
    if (cmd.insert) begin
      idx_r <= t_r;
      sum_r <= '0;
    end else if (cmd.sum_step) begin
      idx_r <= idx_r + 1'b1;
      sum_r <= sum_r + SW'(cell_r[idx_r[PW-1:0]]);
    end
  end

  // fill count and write pointer
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      fill_r <= '0;
      wp_r   <= '0;
    end else if (cmd.start) begin
      wp_r <= wp_use;
    end else if (cmd.insert) begin
      if (!full) fill_r <= fill_r + 1'b1;
      wp_r <= (wp_inc >= w_r) ? '0 : wp_inc[PW-1:0];
    end
  end

  swtm_div #(.SW(SW), .DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (w_r - {t_r[CW-2:0], 1'b0}),
    .busy     (div_busy),
    .quotient (quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_average_r   <= full ? AVG_BITS'(quot) : '0;
      out_ready_res_r <= full;
    end
  end

  assign sts.full     = full;
  assign sts.sum_done = idx_r == w_r - t_r;
  assign sts.div_busy = div_busy;
  assign sts.out_busy = out_valid_r;

  assign out_valid     = out_valid_r;
  assign out_average   = out_average_r;
  assign out_ready_res = out_ready_res_r;

endmodule

### rtl/core/sliding_window_trimmed_mean_unit.sv
// Sliding-window trimmed mean: one word in, one result out, one at a time.
// With a full window, the delay is set by the serial middle sum and the bit-per-cycle
// divider; while the window fills, the sum and divide steps are skipped.
// The next word is taken on return to idle, once the previous one is through.
// A waiting result sits in the output register while the next word is taken.
// Sync active-low reset empties the window, settings go to 32 and 1; any write empties the window too.
module sliding_window_trimmed_mean_unit #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swtm_pkg::AVG_BITS-1:0] out_average,
  output logic                          out_ready_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import swtm_pkg::*;

  logic [WSIZE_BITS-1:0] wsize_r;
  logic [TRIM_BITS-1:0]  trim_r;
  logic                  cfg_we;
  cmd_t                  cmd;
  sts_t                  sts;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WSIZE_RESET;
      trim_r  <= TRIM_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_WINDOW_SIZE: wsize_r <= pwdata[WSIZE_BITS-1:0];
        REG_TRIM_COUNT:  trim_r  <= pwdata[TRIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_TRIM_COUNT) ? 32'(trim_r) : 32'(wsize_r);

  swtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  swtm_dp #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .clear         (cfg_we),
    .cfg_wsize     (wsize_r),
    .cfg_trim      (trim_r),
    .in_sample     (in_sample),
    .out_ready     (out_ready),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_average   (out_average),
    .out_ready_res (out_ready_res)
  );

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while another is in flight");

  // a not-ready result carries a zero average
  a_zero_when_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready_res |-> out_average == '0)
    else $error("non-zero average without ready");

  // a stalled result holds until taken
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average)
      && $stable(out_ready_res))
    else $error("result dropped or changed while stalled");

endmodule

### verif/swtm_checker.sv
// Checker for the sliding-window trimmed mean unit: follows the register port,
// predicts one result per accepted word and compares it on the result channel.
// Depends on swtm_pkg for register indexes and field widths.
`timescale 1ns / 100ps

module swtm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [15:0]                   in_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [swtm_pkg::AVG_BITS-1:0] out_average,
  input  logic                          out_ready_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output int                            fail_count,
  output int                            pending,
  output int                            checked_count
);
  import swtm_pkg::*;

  typedef struct packed {
    logic [AVG_BITS-1:0] average;
    logic                full;
  } mean_t;

  mean_t                 mean_q[$];
  logic [WSIZE_BITS-1:0] wsize_reg;
  logic [TRIM_BITS-1:0]  trim_reg;
  logic [15:0]           ring[32];
  logic [15:0]           sorted_vals[32];
  int                    fill;
  int                    wptr;

  assign pending = mean_q.size();

  // place v into the ascending store of n entries
  task automatic sorted_place(input int n, input logic [15:0] v);
    int k;
    k = n;
    while (k > 0 && sorted_vals[k-1] > v) begin
      sorted_vals[k] = sorted_vals[k-1];
      k--;
    end
    sorted_vals[k] = v;
  endtask

  // update the window with one word and queue the mean it should give
  task automatic predict_mean(input logic [15:0] s);
    int    w, t, k, sum;
    mean_t m;
    w = wsize_reg;
    if (w < 3) w = 3;
    if (w > 32) w = 32;
    t = trim_reg;
    if (2 * t >= w) t = (w - 1) / 2;
    if (wptr >= w) wptr = 0;
    if (fill < w) begin
      sorted_place(fill, s);
      fill++;
    end else begin
      // drop the oldest word from the sorted store
      k = 0;
      while (k < w && sorted_vals[k] != ring[wptr]) k++;
      if (k >= w) k = w - 1;
      while (k + 1 < w) begin
        sorted_vals[k] = sorted_vals[k+1];
        k++;
      end
      sorted_place(w - 1, s);
    end
    ring[wptr] = s;
    wptr++;
    if (wptr >= w) wptr = 0;
    m = '0;
    if (fill >= w) begin
      sum = 0;
      for (k = t; k < w - t; k++) sum += sorted_vals[k];
      m.average = AVG_BITS'(sum / (w - 2 * t));
      m.full    = 1'b1;
    end
    mean_q = {mean_q, m};
  endtask

  always @(posedge clk) begin
    mean_t e;
    if (!rst_n) begin
      wsize_reg = WSIZE_RESET;
      trim_reg  = TRIM_RESET;
      fill      = 0;
      wptr      = 0;
      mean_q.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      // register write empties the window
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WINDOW_SIZE) wsize_reg = pwdata[WSIZE_BITS-1:0];
        else trim_reg = pwdata[TRIM_BITS-1:0];
        fill = 0;
        wptr = 0;
      end
      if (in_valid && in_ready) predict_mean(in_sample);
      if (out_valid && out_ready) begin
        if (mean_q.size() == 0) begin
          $display("%0t: unexpected result average=%0d ready_res=%0b", $time,
                   out_average, out_ready_res);
          fail_count++;
        end else begin
          e = mean_q.pop_front();
          checked_count++;
          if (out_average !== e.average) begin
            $display("%0t: average expected %0d actual %0d", $time, e.average,
                     out_average);
            fail_count++;
          end
          if (out_ready_res !== e.full) begin
            $display("%0t: ready_res expected %0b actual %0b", $time, e.full,
                     out_ready_res);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### verif/tb_sliding_window_trimmed_mean_unit.sv
// Top of the trimmed mean testbench: clock, reset, word and register stimulus,
// receiver stalls and verdict. Depends on swtm_pkg, the unit and swtm_checker.
`timescale 1ns / 100ps

module tb_sliding_window_trimmed_mean_unit;
  import swtm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_average;
  logic        out_ready_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, checked_count;
  int          cycles = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;

  always #2 clk = ~clk;

  sliding_window_trimmed_mean_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_average(out_average),
    .out_ready_res(out_ready_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  swtm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_average(out_average),
    .out_ready_res(out_ready_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending), .checked_count(checked_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sliding_window_trimmed_mean_unit: FAILED **");
      $finish;
    end
  end

  // receiver: free-running, steady stalls or random stalls, changed now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= (stall_left % 7) < 3;
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // one word; valid stays high inside a burst, drops in the gaps
  task automatic send_word(input logic [15:0] s);
    in_valid = 1'b1;
    in_sample = s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [15:0] rand_word(input int kind);
    case (kind)
      0: return 16'(($urandom_range(0, 1)) ? 16'hffff : 16'h0000);
      1: return 16'($urandom_range(0, 7));
      2: return 16'($urandom_range(65528, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int wsizes[10] = '{3, 3, 3, 32, 32, 0, 63, 17, 2, 33};
    int trims[10]  = '{1, 0, 15, 15, 0, 1, 3, 5, 15, 9};
    int kind;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes and duplicates under the reset settings
    for (int i = 0; i < 24; i++)
      send_word(i < 8 ? 16'h0000 : (i < 16 ? 16'hffff : 16'((i % 2) ? 16'hffff : 0)));

    // phases over several settings, fixed list first, then random ones
    for (int p = 0; p < 16; p++) begin
      wait_idle();
      if (p < 10) begin
        write_reg(REG_WINDOW_SIZE, wsizes[p]);
        write_reg(REG_TRIM_COUNT, trims[p]);
      end else begin
        write_reg(REG_TRIM_COUNT, $urandom_range(0, 15));
        write_reg(REG_WINDOW_SIZE, $urandom_range(0, 63));
      end
      kind = $urandom_range(0, 3);
      for (int i = 0; i < 75; i++) begin
        if (p == 4 && i == 40) wait_idle();
        send_word(rand_word(($urandom_range(0, 3) == 0) ? kind : 3));
      end
    end

    wait_idle();
    $display("Sent %0d words over 17 register settings, %0d results checked.",
             words_sent, checked_count);
    if (fail_count == 0) begin
      $display("** sliding_window_trimmed_mean_unit: PASSED **");
    end else begin
      $display("** sliding_window_trimmed_mean_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/swtm_pkg.sv
rtl/core/swtm_div.sv
rtl/core/swtm_ctrl.sv
rtl/core/swtm_dp.sv
rtl/core/sliding_window_trimmed_mean_unit.sv
verif/swtm_checker.sv
verif/tb_sliding_window_trimmed_mean_unit.sv
